FILE: hdl/dcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Day-cycle clock package
// Field widths, register indexes, opcodes and the small structs shared by the
// counter cells, the window unit and the top level.
// ----------------------------------------------------------------------------
package dcc_pkg;

    localparam int DAY_W    = 4;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int MOD_W    = 11;   // minutes of the day, with room for odd bounds

    localparam int SECONDS_PER_MINUTE = 60;
    localparam int MINUTES_PER_HOUR   = 60;
    localparam int HOURS_PER_DAY      = 24;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 6;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIMER_ENABLE        = 3'd0,
        REG_WINDOW_DAY          = 3'd1,
        REG_WINDOW_START_HOUR   = 3'd2,
        REG_WINDOW_START_MINUTE = 3'd3,
        REG_WINDOW_END_HOUR     = 3'd4,
        REG_WINDOW_END_MINUTE   = 3'd5
    } dcc_reg_e_t;

    // Per-beat control handed to every counter cell.
    typedef struct packed {
        logic load;
        logic step;
    } dcc_ctrl_t;

    // Time as it will stand after the beat being accepted.
    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } dcc_time_t;

    // Hour and minute folded into minutes of the day.
    function automatic logic [MOD_W-1:0] minutes_of_day(
        input logic [HOUR_W-1:0]   hour,
        input logic [MINUTE_W-1:0] minute
    );
        logic [MOD_W-1:0] scaled;
        scaled = MOD_W'(hour) * MOD_W'(MINUTES_PER_HOUR);
        return scaled + MOD_W'(minute);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/dcc_count_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counter cell
// One digit of the clock: counts modulo MODULUS, takes a carry from the
// cell below and passes one to the cell above, loads a saturated set value.
// ----------------------------------------------------------------------------
module dcc_count_cell #(
    parameter int WIDTH   = 6,
    parameter int MODULUS = 60
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dcc_pkg::dcc_ctrl_t ctrl,
    input  wire logic               carry_in,
    input  wire logic [WIDTH-1:0]   set_value,
    output logic      [WIDTH-1:0]   count_next,
    output logic                    carry_out
);

    localparam logic [WIDTH-1:0] LAST = WIDTH'(MODULUS - 1);

    logic [WIDTH-1:0] count_reg;
    logic             at_last;

    assign at_last   = (count_reg == LAST);
    assign carry_out = carry_in && at_last;

    always_comb begin
        priority if (ctrl.load) begin
            count_next = (set_value > LAST) ? LAST : set_value;
        end else if (ctrl.step && carry_in) begin
            count_next = at_last ? '0 : WIDTH'(count_reg + 1'b1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/dcc_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window unit
// Holds the window registers and decides whether a time lies in the window.
// ----------------------------------------------------------------------------
module dcc_window (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_write,
    input  wire logic [dcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [dcc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire dcc_pkg::dcc_time_t                 time_next,
    output logic                                    window_active
);

    logic                           enable_reg;
    logic [dcc_pkg::DAY_W-1:0]      day_reg;
    logic [dcc_pkg::HOUR_W-1:0]     start_hour_reg;
    logic [dcc_pkg::MINUTE_W-1:0]   start_minute_reg;
    logic [dcc_pkg::HOUR_W-1:0]     end_hour_reg;
    logic [dcc_pkg::MINUTE_W-1:0]   end_minute_reg;

    logic [dcc_pkg::MOD_W-1:0] now_mod;
    logic [dcc_pkg::MOD_W-1:0] lo_mod;
    logic [dcc_pkg::MOD_W-1:0] hi_mod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg       <= 1'b0;
            day_reg          <= '0;
            start_hour_reg   <= '0;
            start_minute_reg <= '0;
            end_hour_reg     <= '0;
            end_minute_reg   <= '0;
        end else if (cfg_write) begin
            unique case (dcc_pkg::dcc_reg_e_t'(cfg_index))
                dcc_pkg::REG_TIMER_ENABLE: begin
                    enable_reg <= cfg_data[0];
                end
                dcc_pkg::REG_WINDOW_DAY: begin
                    day_reg <= cfg_data[dcc_pkg::DAY_W-1:0];
                end
                dcc_pkg::REG_WINDOW_START_HOUR: begin
                    start_hour_reg <= cfg_data[dcc_pkg::HOUR_W-1:0];
                end
                dcc_pkg::REG_WINDOW_START_MINUTE: begin
                    start_minute_reg <= cfg_data[dcc_pkg::MINUTE_W-1:0];
                end
                dcc_pkg::REG_WINDOW_END_HOUR: begin
                    end_hour_reg <= cfg_data[dcc_pkg::HOUR_W-1:0];
                end
                dcc_pkg::REG_WINDOW_END_MINUTE: begin
                    end_minute_reg <= cfg_data[dcc_pkg::MINUTE_W-1:0];
                end
                default: begin
                    // Indexes past the register list are dropped.
                end
            endcase
        end
    end

    // Bounds are compared as minutes of the day, so the span is half open
    // and never wraps past midnight.
    assign now_mod = dcc_pkg::minutes_of_day(time_next.hour, time_next.minute);
    assign lo_mod  = dcc_pkg::minutes_of_day(start_hour_reg, start_minute_reg);
    assign hi_mod  = dcc_pkg::minutes_of_day(end_hour_reg, end_minute_reg);

    assign window_active = enable_reg && (time_next.day == day_reg)
                           && (now_mod >= lo_mod) && (now_mod < hi_mod);

endmodule
`default_nettype wire

FILE: hdl/day_cycle_clock_with_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Day-cycle clock with on-window
// Wall clock of seconds, minutes, hours and a day index, with a daily window.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle and returns exactly one result
// beat for each, in the cycle after acceptance; a stalled result waits in the
// output register while the next beat is still taken whenever that register
// is being emptied in the same cycle. A beat with tuser low is a one-second
// tick; with tuser high it loads day, hour, minute and second from tdata,
// each saturated to its top legal value. The clock is a row of four counter
// cells (second, minute, hour, day) that ripple a carry from one to the next;
// that carry row, followed by the window compare, is the one path between
// the input and the output register and sets the rate of one beat a cycle.
// The result carries the time after the beat and a flag that is high when
// the timer is enabled, the day matches the window day, and hour:minute lies
// in the half-open span from window start to window end. Window registers
// are written through the cfg port, ready whenever the block is out of reset;
// the user is to write them only while no beat is in flight, which the block
// does not enforce. Neither port takes anything while reset is held.
// ----------------------------------------------------------------------------
module day_cycle_clock_with_window #(
    parameter int DAYS_IN_CYCLE = 14
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // tdata: set_day[3:0], set_hour[8:4], set_minute[14:9], set_second[20:15]
    input  wire logic [23:0]                        s_tdata,
    // tuser: opcode[0]
    input  wire logic                               s_tuser,
    // Result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // tdata: day_now[3:0], hour_now[8:4], minute_now[14:9], second_now[20:15],
    //        window_active[21]
    output logic [23:0]                             m_tdata,
    // Configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [dcc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic s_accept;
    logic m_accept;

    dcc_pkg::dcc_ctrl_t ctrl;

    logic [dcc_pkg::DAY_W-1:0]    day_next;
    logic [dcc_pkg::HOUR_W-1:0]   hour_next;
    logic [dcc_pkg::MINUTE_W-1:0] minute_next;
    logic [dcc_pkg::SECOND_W-1:0] second_next;

    logic carry_second;
    logic carry_minute;
    logic carry_hour;
    logic carry_day;

    dcc_pkg::dcc_time_t time_next;
    logic               window_next;

    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic [23:0] m_tdata_next;

    // The output register frees up either when empty or when its beat leaves.
    // Nothing is taken while reset is held, since the counters ignore it then.
    assign s_tready = aresetn && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid_reg && m_tready;

    assign ctrl.load = s_accept && (s_tuser == dcc_pkg::OP_SET);
    assign ctrl.step = s_accept && (s_tuser == dcc_pkg::OP_TICK);

    // The carry runs from seconds up to days within the cycle of the beat.
    dcc_count_cell #(
        .WIDTH   (dcc_pkg::SECOND_W),
        .MODULUS (dcc_pkg::SECONDS_PER_MINUTE)
    ) u_second (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .carry_in   (1'b1),
        .set_value  (s_tdata[20:15]),
        .count_next (second_next),
        .carry_out  (carry_second)
    );

    dcc_count_cell #(
        .WIDTH   (dcc_pkg::MINUTE_W),
        .MODULUS (dcc_pkg::MINUTES_PER_HOUR)
    ) u_minute (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .carry_in   (carry_second),
        .set_value  (s_tdata[14:9]),
        .count_next (minute_next),
        .carry_out  (carry_minute)
    );

    dcc_count_cell #(
        .WIDTH   (dcc_pkg::HOUR_W),
        .MODULUS (dcc_pkg::HOURS_PER_DAY)
    ) u_hour (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .carry_in   (carry_minute),
        .set_value  (s_tdata[8:4]),
        .count_next (hour_next),
        .carry_out  (carry_hour)
    );

    dcc_count_cell #(
        .WIDTH   (dcc_pkg::DAY_W),
        .MODULUS (DAYS_IN_CYCLE)
    ) u_day (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .carry_in   (carry_hour),
        .set_value  (s_tdata[3:0]),
        .count_next (day_next),
        .carry_out  (carry_day)
    );

    assign time_next.day    = day_next;
    assign time_next.hour   = hour_next;
    assign time_next.minute = minute_next;

    assign cfg_ready = aresetn;

    dcc_window u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .time_next     (time_next),
        .window_active (window_next)
    );

    // The day carry leaving the top cell wraps the cycle; nothing sits above
    // it, so it is masked off and the spare top bits of the result word stay zero.
    assign m_tdata_next = {1'b0, carry_day && 1'b0, window_next, second_next,
                           minute_next, hour_next, day_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_accept) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Every result the block shows holds a legal time.
    a_legal_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[20:15] < 6'(dcc_pkg::SECONDS_PER_MINUTE))
                  && (m_tdata[14:9] < 6'(dcc_pkg::MINUTES_PER_HOUR))
                  && (m_tdata[8:4] < 5'(dcc_pkg::HOURS_PER_DAY))
                  && (int'(m_tdata[3:0]) < DAYS_IN_CYCLE))
        else $error("result time out of range");

    // A tick that does not roll the minute over shows the stepped second and minute.
    a_tick_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step && !carry_second) |=>
            (m_tdata[20:15] == 6'($past(second_next) ))
            && (m_tdata[14:9] == $past(minute_next)))
        else $error("tick did not advance the second");

    // An accepted beat always leaves a result waiting in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted beat produced no result");

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day-cycle clock with on-window: self-checking testbench
// Drives set and tick beats into the clock, keeps its own copy of the wall
// clock and of the window registers, and checks every result beat field by
// field against the time and window flag predicted for the beat that caused
// it. The run steps through several window settings, from the extremes to
// random ones; in the random phases but the last, both sides idle in bursts.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DAYS         = 14;
    localparam int MIN_PER_DAY  = dcc_pkg::HOURS_PER_DAY * dcc_pkg::MINUTES_PER_HOUR;
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 40;
    localparam int PHASE_BEATS  = 65;
    localparam int RANDOM_PHASES = 9;
    // Indexes 6 and 7 fit the index field but name no register.
    localparam logic [dcc_pkg::CFG_INDEX_W-1:0] FIRST_UNUSED_INDEX = 3'd6;

    // One input beat, packed in the same order as s_tdata with the opcode on top.
    typedef struct packed {
        logic                         op;
        logic [dcc_pkg::SECOND_W-1:0] second;
        logic [dcc_pkg::MINUTE_W-1:0] minute;
        logic [dcc_pkg::HOUR_W-1:0]   hour;
        logic [dcc_pkg::DAY_W-1:0]    day;
    } clock_cmd_t;

    // One result beat, laid out exactly like m_tdata[21:0].
    typedef struct packed {
        logic                         active;
        logic [dcc_pkg::SECOND_W-1:0] second;
        logic [dcc_pkg::MINUTE_W-1:0] minute;
        logic [dcc_pkg::HOUR_W-1:0]   hour;
        logic [dcc_pkg::DAY_W-1:0]    day;
    } reading_t;

    typedef struct packed {
        logic [dcc_pkg::CFG_INDEX_W-1:0] idx;
        logic [dcc_pkg::CFG_DATA_W-1:0]  data;
    } reg_write_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [23:0]                     s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [23:0]                     m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [dcc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dcc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Stimulus and expectation stores.
    clock_cmd_t beats_to_send[$];
    reading_t   expected_readings[$];
    reg_write_t reg_writes[$];
    clock_cmd_t beat_on_bus;

    // Predicted clock and window registers.
    logic [dcc_pkg::DAY_W-1:0]    clk_day    = '0;
    logic [dcc_pkg::HOUR_W-1:0]   clk_hour   = '0;
    logic [dcc_pkg::MINUTE_W-1:0] clk_minute = '0;
    logic [dcc_pkg::SECOND_W-1:0] clk_second = '0;
    logic                         win_en     = 1'b0;
    logic [dcc_pkg::DAY_W-1:0]    win_day    = '0;
    logic [dcc_pkg::HOUR_W-1:0]   win_sh     = '0;
    logic [dcc_pkg::MINUTE_W-1:0] win_sm     = '0;
    logic [dcc_pkg::HOUR_W-1:0]   win_eh     = '0;
    logic [dcc_pkg::MINUTE_W-1:0] win_em     = '0;

    int errors        = 0;
    int beats_queued  = 0;
    int quiet_cycles  = 0;
    int src_gap       = 0;
    int sink_gap      = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    day_cycle_clock_with_window #(
        .DAYS_IN_CYCLE(DAYS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // tdata: set_day[3:0], set_hour[8:4], set_minute[14:9], set_second[20:15]
        .s_tdata  (s_tdata),
        // tuser: opcode[0]
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // tdata: day_now[3:0], hour_now[8:4], minute_now[14:9], second_now[20:15],
        //        window_active[21]
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Applies one beat to the predicted clock and queues the reading it yields.
    task automatic advance_clock(input clock_cmd_t cmd);
        reading_t r;
        int now_m, lo_m, hi_m;
        if (cmd.op == dcc_pkg::OP_SET) begin
            // Out-of-range set values saturate to the top legal value.
            clk_day    = (cmd.day >= DAYS) ? dcc_pkg::DAY_W'(DAYS - 1) : cmd.day;
            clk_hour   = (cmd.hour > 23) ? dcc_pkg::HOUR_W'(23) : cmd.hour;
            clk_minute = (cmd.minute > 59) ? dcc_pkg::MINUTE_W'(59) : cmd.minute;
            clk_second = (cmd.second > 59) ? dcc_pkg::SECOND_W'(59) : cmd.second;
        end else if (clk_second != 59) begin
            clk_second++;
        end else begin
            clk_second = '0;
            if (clk_minute != 59) begin
                clk_minute++;
            end else begin
                clk_minute = '0;
                if (clk_hour != 23) begin
                    clk_hour++;
                end else begin
                    clk_hour = '0;
                    clk_day  = (clk_day == DAYS - 1) ? '0 : clk_day + 1'b1;
                end
            end
        end
        // Bounds are taken as given, so odd hours or minutes just shift them.
        now_m = clk_hour;
        now_m = now_m * dcc_pkg::MINUTES_PER_HOUR + clk_minute;
        lo_m  = win_sh;
        lo_m  = lo_m * dcc_pkg::MINUTES_PER_HOUR + win_sm;
        hi_m  = win_eh;
        hi_m  = hi_m * dcc_pkg::MINUTES_PER_HOUR + win_em;
        r.day    = clk_day;
        r.hour   = clk_hour;
        r.minute = clk_minute;
        r.second = clk_second;
        r.active = win_en && (clk_day == win_day) && (now_m >= lo_m) && (now_m < hi_m);
        expected_readings.push_back(r);
    endtask

    // Input driver: holds a beat until it is taken, then moves on or idles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                advance_clock(beat_on_bus);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (beats_to_send.size() != 0 && src_idle_pct != 0 &&
                             $urandom_range(1, 100) <= src_idle_pct) begin
                    src_gap = $urandom_range(0, 14);
                    s_tvalid <= 1'b0;
                end else if (beats_to_send.size() != 0) begin
                    beat_on_bus = beats_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, beat_on_bus.second, beat_on_bus.minute,
                                 beat_on_bus.hour, beat_on_bus.day};
                    s_tuser  <= beat_on_bus.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Register write driver; the predicted registers change when a write is taken.
    always @(posedge aclk) begin
        reg_write_t w;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dcc_pkg::REG_TIMER_ENABLE:        win_en = cfg_data[0];
                    dcc_pkg::REG_WINDOW_DAY:          win_day = cfg_data[dcc_pkg::DAY_W-1:0];
                    dcc_pkg::REG_WINDOW_START_HOUR:   win_sh = cfg_data[dcc_pkg::HOUR_W-1:0];
                    dcc_pkg::REG_WINDOW_START_MINUTE: win_sm = cfg_data[dcc_pkg::MINUTE_W-1:0];
                    dcc_pkg::REG_WINDOW_END_HOUR:     win_eh = cfg_data[dcc_pkg::HOUR_W-1:0];
                    dcc_pkg::REG_WINDOW_END_MINUTE:   win_em = cfg_data[dcc_pkg::MINUTE_W-1:0];
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_writes.size() != 0) begin
                    w = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.idx;
                    cfg_data  <= w.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        reading_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[21:0];
                if (expected_readings.size() == 0) begin
                    report_mismatch("result beat with nothing pending", got, 0);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.day != want.day)
                        report_mismatch("day_now", got.day, want.day);
                    if (got.hour != want.hour)
                        report_mismatch("hour_now", got.hour, want.hour);
                    if (got.minute != want.minute)
                        report_mismatch("minute_now", got.minute, want.minute);
                    if (got.second != want.second)
                        report_mismatch("second_now", got.second, want.second);
                    if (got.active != want.active)
                        report_mismatch("window_active", got.active, want.active);
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (sink_idle_pct != 0 && $urandom_range(1, 100) <= sink_idle_pct) begin
                sink_gap = $urandom_range(0, 14);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: counts cycles in which no channel moves a beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Fields are cut to their widths here, so callers may pass any integer.
    task automatic push_cmd(input logic op, input int d, input int h, input int m,
                            input int s);
        clock_cmd_t c;
        c.op     = op;
        c.day    = d[dcc_pkg::DAY_W-1:0];
        c.hour   = h[dcc_pkg::HOUR_W-1:0];
        c.minute = m[dcc_pkg::MINUTE_W-1:0];
        c.second = s[dcc_pkg::SECOND_W-1:0];
        beats_to_send.push_back(c);
        beats_queued++;
    endtask

    // A tick whose set fields carry noise that the block has to ignore.
    task automatic push_tick();
        push_cmd(dcc_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Waits until every beat and write has gone through and every result is back.
    // Sampling on the falling edge sees the drivers after they have settled.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (beats_to_send.size() != 0 || s_tvalid || expected_readings.size() != 0 ||
               reg_writes.size() != 0 || cfg_valid);
        repeat (2) @(posedge aclk);
    endtask

    task automatic push_write(input logic [dcc_pkg::CFG_INDEX_W-1:0] idx, input int value);
        reg_write_t w;
        w.idx  = idx;
        w.data = value[dcc_pkg::CFG_DATA_W-1:0];
        reg_writes.push_back(w);
    endtask

    // Queues all six window registers, sometimes after a write to an unused index,
    // and waits for them to land.
    task automatic set_window(input int en, input int d, input int sh, input int sm,
                              input int eh, input int em);
        if ($urandom_range(0, 1))
            push_write(FIRST_UNUSED_INDEX + dcc_pkg::CFG_INDEX_W'($urandom_range(0, 1)),
                       $urandom);
        push_write(dcc_pkg::REG_TIMER_ENABLE, en);
        push_write(dcc_pkg::REG_WINDOW_DAY, d);
        push_write(dcc_pkg::REG_WINDOW_START_HOUR, sh);
        push_write(dcc_pkg::REG_WINDOW_START_MINUTE, sm);
        push_write(dcc_pkg::REG_WINDOW_END_HOUR, eh);
        push_write(dcc_pkg::REG_WINDOW_END_MINUTE, em);
        wait_idle();
    endtask

    // Most segments set the clock just short of a window edge or a carry point
    // and then tick across it; the rest are raw sets and lone ticks.
    task automatic add_segment();
        int pick, mark, run;
        int dd;
        if ($urandom_range(0, 3) == 0) begin
            run = $urandom_range(1, 3);
            repeat (run) begin
                if ($urandom_range(0, 1))
                    push_cmd(dcc_pkg::OP_SET, $urandom, $urandom, $urandom, $urandom);
                else
                    push_tick();
            end
        end else begin
            pick = $urandom_range(0, 4);
            case (pick)
                0: mark = win_sh * dcc_pkg::MINUTES_PER_HOUR + win_sm;
                1: mark = win_eh * dcc_pkg::MINUTES_PER_HOUR + win_em;
                2: mark = MIN_PER_DAY;
                3: mark = dcc_pkg::MINUTES_PER_HOUR * $urandom_range(1, 23);
                default: mark = $urandom_range(1, MIN_PER_DAY - 1);
            endcase
            mark = mark - 1;
            if (mark < 0)
                mark = 0;
            if (mark > MIN_PER_DAY - 1)
                mark = MIN_PER_DAY - 1;
            if (win_day < DAYS && $urandom_range(0, 9) < 7)
                dd = win_day;
            else
                dd = $urandom_range(0, DAYS - 1);
            if (pick == 2 && $urandom_range(0, 1))
                dd = DAYS - 1;
            push_cmd(dcc_pkg::OP_SET, dd, mark / dcc_pkg::MINUTES_PER_HOUR,
                     mark % dcc_pkg::MINUTES_PER_HOUR, $urandom_range(40, 59));
            run = $urandom_range(4, 40);
            repeat (run) push_tick();
        end
    endtask

    initial begin
        int ph, target, hh, mm, lo_m, hi_m, waited;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats under the reset registers, where the window is empty.
        push_tick();                                          // first tick out of reset
        push_cmd(dcc_pkg::OP_SET, 0, 0, 0, 0);
        push_cmd(dcc_pkg::OP_SET, DAYS - 1, 23, 59, 59);      // last second of the cycle
        push_tick();                                          // wraps to day zero
        push_cmd(dcc_pkg::OP_SET, 'hF, 'h1F, 'h3F, 'h3F);     // every field saturates
        push_cmd(dcc_pkg::OP_SET, DAYS, 24, 60, 60);          // just past every top value
        push_tick();
        push_cmd(dcc_pkg::OP_SET, 2, 0, 59, 59);
        push_tick();                                          // carry into the hour
        push_cmd(dcc_pkg::OP_SET, 5, 23, 59, 59);
        push_tick();                                          // carry into the day
        wait_idle();

        // A narrow window on day 3 from 10:20 up to 10:22, entered and left.
        set_window(1, 3, 10, 20, 10, 22);
        push_cmd(dcc_pkg::OP_SET, 3, 10, 19, 59);
        push_tick();
        push_tick();
        push_cmd(dcc_pkg::OP_SET, 3, 10, 21, 59);
        push_tick();                                          // end bound is exclusive
        push_cmd(dcc_pkg::OP_SET, 4, 10, 20, 30);             // right time, wrong day
        push_cmd(dcc_pkg::OP_SET, 3, 10, 20, 0);
        wait_idle();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: set_window(1, 0, 0, 0, 23, 59);
                1: set_window({5'($urandom), 1'b1}, DAYS - 1, 23, 58, 'h3F, 'h3F);
                2: begin
                    // Start later than end: nothing can match.
                    hh = $urandom_range(1, 23);
                    mm = $urandom_range(0, 59);
                    set_window(1, $urandom_range(0, DAYS - 1), hh, mm, hh - 1, mm);
                end
                3: begin
                    hh = $urandom_range(0, 23);
                    mm = $urandom_range(0, 59);
                    set_window(1, $urandom_range(0, DAYS - 1), hh, mm, hh, mm);
                end
                4: set_window({5'($urandom), 1'b0}, $urandom_range(0, DAYS - 1), 0, 0, 23, 59);
                5: set_window(1, $urandom_range(DAYS, 15), 0, 0, 23, 59);
                6: set_window($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                default: begin
                    lo_m = $urandom_range(0, MIN_PER_DAY - 2);
                    hi_m = $urandom_range(lo_m + 1, lo_m + 40);
                    if (hi_m > MIN_PER_DAY - 1)
                        hi_m = MIN_PER_DAY - 1;
                    set_window(1, $urandom_range(0, DAYS - 1),
                               lo_m / dcc_pkg::MINUTES_PER_HOUR,
                               lo_m % dcc_pkg::MINUTES_PER_HOUR,
                               hi_m / dcc_pkg::MINUTES_PER_HOUR,
                               hi_m % dcc_pkg::MINUTES_PER_HOUR);
                end
            endcase
            // Idling varies by phase; the last phase runs at full rate.
            if (ph == RANDOM_PHASES - 1) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = 10 * $urandom_range(0, 4);
                sink_idle_pct = 10 * $urandom_range(0, 4);
            end
            target = beats_queued + PHASE_BEATS;
            while (beats_queued < target)
                add_segment();
            wait_idle();
        end

        // wait_idle already drained the results; give any straggler a bounded chance.
        waited = 0;
        while (expected_readings.size() != 0 && waited < 100) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
        if (expected_readings.size() != 0)
            report_mismatch("results never returned", 0, expected_readings.size());

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
